FILE: sv/scale_weight_frame_decoder_defines.svh
// Assertion macros shared by the frame decoder checkers.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef SCALE_WEIGHT_FRAME_DECODER_DEFINES_SVH
`define SCALE_WEIGHT_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SWFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SWFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/swfd_pkg.sv
// Shared types and constants of the scale weight frame decoder.
// No dependencies; imported by every decoder module.
`default_nettype none

package swfd_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LENGTH = 20;
  localparam int unsigned POS_W        = $clog2(FRAME_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_LENGTH - 1);
  localparam logic [POS_W-1:0] POS_PRODUCT = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SIGN    = POS_W'(6);
  localparam logic [POS_W-1:0] POS_MAG_HI  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_MAG_MID = POS_W'(8);
  localparam logic [POS_W-1:0] POS_MAG_LO  = POS_W'(9);

  // Sign byte that marks a negative weight ('-')
  localparam logic [7:0] NEG_SIGN_MARK = 8'd45;

  // Field widths
  localparam int unsigned MAG_W    = 24;
  localparam int unsigned WEIGHT_W = MAG_W + 1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TYPE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_TYPE  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] PRODUCT_CODE_RST = 8'd3;
  localparam logic [7:0] WEIGHT_TYPE_RST  = 8'd11;
  localparam logic [7:0] SYSTEM_TYPE_RST  = 8'd10;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_WEIGHT    = 2'd0,
    KIND_CSUM_ERR  = 2'd1,
    KIND_TARE      = 2'd2,
    KIND_UNKNOWN   = 2'd3
  } kind_t;

  // Configuration seen by the classifier
  typedef struct packed {
    logic [7:0] product_code;
    logic [7:0] weight_type_code;
    logic [7:0] system_type_code;
  } cfg_t;

  // Frame state captured so far
  typedef struct packed {
    logic             last;
    logic [7:0]       xor_acc;
    logic [7:0]       product_byte;
    logic [7:0]       type_byte;
    logic [7:0]       sign_byte;
    logic [MAG_W-1:0] magnitude;
  } frame_t;

endpackage

`default_nettype wire

FILE: sv/swfd_frame_capture.sv
// Byte position counter, running XOR and field capture of one frame.
// Depends on swfd_pkg.
`default_nettype none

module swfd_frame_capture (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            beat_fire,
  input  wire logic [7:0]      rx_byte,
  output swfd_pkg::frame_t     frame
);
  import swfd_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       product_r, product_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       sign_r, sign_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             last;

  assign last = (pos_r == LAST_POS);

  // Advance position and capture fields; clear after the checksum byte
  always_comb begin
    pos_nxt     = pos_r;
    xor_nxt     = xor_r;
    product_nxt = product_r;
    type_nxt    = type_r;
    sign_nxt    = sign_r;
    mag_nxt     = mag_r;
    if (beat_fire) begin
      if (last) begin
        pos_nxt     = '0;
        xor_nxt     = '0;
        product_nxt = '0;
        type_nxt    = '0;
        sign_nxt    = '0;
        mag_nxt     = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        xor_nxt = xor_r ^ rx_byte;
        case (pos_r)
          POS_PRODUCT: product_nxt = rx_byte;
          POS_TYPE:    type_nxt    = rx_byte;
          POS_SIGN:    sign_nxt    = rx_byte;
          POS_MAG_HI:  mag_nxt[23:16] = rx_byte;
          POS_MAG_MID: mag_nxt[15:8]  = rx_byte;
          POS_MAG_LO:  mag_nxt[7:0]   = rx_byte;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      xor_r     <= '0;
      product_r <= '0;
      type_r    <= '0;
      sign_r    <= '0;
      mag_r     <= '0;
    end else begin
      pos_r     <= pos_nxt;
      xor_r     <= xor_nxt;
      product_r <= product_nxt;
      type_r    <= type_nxt;
      sign_r    <= sign_nxt;
      mag_r     <= mag_nxt;
    end
  end

  // Present the frame state to the classifier
  assign frame = '{last:         last,
                   xor_acc:      xor_r,
                   product_byte: product_r,
                   type_byte:    type_r,
                   sign_byte:    sign_r,
                   magnitude:    mag_r};

endmodule

`default_nettype wire

FILE: sv/swfd_classify.sv
// Frame classification and the result register of the decoder.
// Depends on swfd_pkg.
`default_nettype none

module swfd_classify (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            result_fire,
  input  wire logic [7:0]                      csum_byte,
  input  wire swfd_pkg::frame_t                frame,
  input  wire swfd_pkg::cfg_t                  cfg,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic [1:0]                           out_frame_kind,
  output logic signed [swfd_pkg::WEIGHT_W-1:0] out_weight_hundredths
);
  import swfd_pkg::*;

  logic                       prod_ok;
  kind_t                      kind_nxt;
  logic signed [WEIGHT_W-1:0] weight_nxt;
  logic [WEIGHT_W-1:0]        mag_ext;

  logic                       valid_r;
  kind_t                      kind_r;
  logic signed [WEIGHT_W-1:0] weight_r;

  assign prod_ok = (frame.product_byte == cfg.product_code);
  assign mag_ext = {1'b0, frame.magnitude};

  // Decide the kind and signed weight of the finished frame
  always_comb begin
    weight_nxt = '0;
    if (prod_ok && (frame.type_byte == cfg.weight_type_code)) begin
      if (frame.xor_acc == csum_byte) begin
        kind_nxt = KIND_WEIGHT;
        if (frame.sign_byte == NEG_SIGN_MARK) begin
          weight_nxt = $signed(WEIGHT_W'(0) - mag_ext);
        end else begin
          weight_nxt = $signed(mag_ext);
        end
      end else begin
        kind_nxt = KIND_CSUM_ERR;
      end
    end else if (prod_ok && (frame.type_byte == cfg.system_type_code)) begin
      kind_nxt = KIND_TARE;
    end else begin
      kind_nxt = KIND_UNKNOWN;
    end
  end

  // Result register: load on the checksum beat, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (result_fire) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) begin
      kind_r   <= kind_nxt;
      weight_r <= weight_nxt;
    end
  end

  assign out_valid             = valid_r;
  assign out_frame_kind        = kind_r;
  assign out_weight_hundredths = weight_r;

endmodule

`default_nettype wire

FILE: sv/scale_weight_frame_decoder.sv
// Scale weight frame decoder: one received byte per cycle unless a last byte is stalled, one result per frame.
// The result is valid in the cycle after the frame's last byte is accepted.
// Throughput: one byte per cycle; bytes keep flowing while a result waits, and only
// a last byte meeting a held, stalled result is stalled (one-deep result register).
// Reset (synchronous, rst_n low): frame counter and captured fields cleared,
// configuration registers return to product 3, weight type 11, system type 10.
`default_nettype none

module scale_weight_frame_decoder (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic [swfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [7:0]                           cfg_wdata,
  // received byte beats
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [7:0]                           in_rx_byte,
  // result beats
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [1:0]                                out_frame_kind,
  output logic signed [swfd_pkg::WEIGHT_W-1:0]      out_weight_hundredths
);
  import swfd_pkg::*;

  logic [7:0] product_code_r;
  logic [7:0] weight_type_r;
  logic [7:0] system_type_r;
  cfg_t       cfg;
  frame_t     frame;
  logic       in_fire;
  logic       result_fire;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      product_code_r <= PRODUCT_CODE_RST;
      weight_type_r  <= WEIGHT_TYPE_RST;
      system_type_r  <= SYSTEM_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRODUCT_CODE: product_code_r <= cfg_wdata;
        CFG_WEIGHT_TYPE:  weight_type_r  <= cfg_wdata;
        CFG_SYSTEM_TYPE:  system_type_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = '{product_code:     product_code_r,
                 weight_type_code: weight_type_r,
                 system_type_code: system_type_r};

  // Hold only a last byte while the result register is full and stalled
  assign in_stall    = frame.last && out_valid && out_stall;
  assign in_fire     = in_valid && !in_stall;
  assign result_fire = in_fire && frame.last;

  swfd_frame_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_fire (in_fire),
    .rx_byte   (in_rx_byte),
    .frame     (frame)
  );

  swfd_classify u_classify (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .result_fire           (result_fire),
    .csum_byte             (in_rx_byte),
    .frame                 (frame),
    .cfg                   (cfg),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_frame_kind        (out_frame_kind),
    .out_weight_hundredths (out_weight_hundredths)
  );

endmodule

`default_nettype wire

FILE: sv/swfd_checker.sv
// Port-level checker for the scale weight frame decoder, bound to the top level.
// Depends on swfd_pkg and scale_weight_frame_decoder_defines.svh.
`default_nettype none

`include "scale_weight_frame_decoder_defines.svh"

module swfd_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [swfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [7:0]                           cfg_wdata,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_stall,
  input  wire logic [7:0]                           in_rx_byte,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_stall,
  input  wire logic [1:0]                           out_frame_kind,
  input  wire logic signed [swfd_pkg::WEIGHT_W-1:0] out_weight_hundredths
);
  import swfd_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_we ^ (|cfg_index) ^ (|cfg_wdata) ^ in_valid ^ (|in_rx_byte);

  // A stalled result beat holds its payload
  `SWFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_frame_kind) && $stable(out_weight_hundredths), "result beat changed while stalled")

  // Input is held back only by a full, stalled result register
  `SWFD_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked result")

  // Weight is zero for every kind but a valid weight
  `SWFD_ASSERT_NOW(a_weight_zero, out_valid && (out_frame_kind != KIND_WEIGHT), out_weight_hundredths == '0, "nonzero weight on a non-weight result")

  // Magnitude never exceeds 24 bits, so the most negative code cannot appear
  `SWFD_ASSERT_NOW(a_weight_range, out_valid, out_weight_hundredths != {1'b1, {MAG_W{1'b0}}}, "weight outside the 24-bit magnitude range")

endmodule

bind scale_weight_frame_decoder swfd_checker u_swfd_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the scale weight frame decoder: streams whole byte frames,
// decodes them alongside the block and compares every result beat field by field.
// Depends on swfd_pkg and the scale_weight_frame_decoder RTL.

module testbench;
  import swfd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int FRAMES_PER_PHASE = 15;
  localparam int SETTLE_CYCLES    = 6;

  typedef struct {
    kind_t                      kind;
    logic signed [WEIGHT_W-1:0] weight;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_frame_kind;
  logic signed [WEIGHT_W-1:0] out_weight_hundredths;

  // Bytes waiting to be sent and frame results waiting to come out
  logic [7:0] rx_stream[$];
  frame_result_t decoded_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;

  // Decoder copy: configuration and frame state
  logic [7:0] cfg_product = PRODUCT_CODE_RST;
  logic [7:0] cfg_weight_type = WEIGHT_TYPE_RST;
  logic [7:0] cfg_system_type = SYSTEM_TYPE_RST;
  logic [POS_W-1:0] fr_pos = '0;
  logic [7:0] fr_xor = '0;
  logic [7:0] fr_product = '0;
  logic [7:0] fr_type = '0;
  logic [7:0] fr_sign = '0;
  logic [MAG_W-1:0] fr_mag = '0;

  scale_weight_frame_decoder uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_kind       (out_frame_kind),
    .out_weight_hundredths(out_weight_hundredths)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Capture one accepted byte; on the frame's last byte classify and queue the result
  task automatic decode_rx_byte(input logic [7:0] b);
    frame_result_t r;
    logic [WEIGHT_W-1:0] mag_ext;
    if (fr_pos < LAST_POS) begin
      case (fr_pos)
        POS_PRODUCT: fr_product = b;
        POS_TYPE:    fr_type = b;
        POS_SIGN:    fr_sign = b;
        POS_MAG_HI:  fr_mag[23:16] = b;
        POS_MAG_MID: fr_mag[15:8] = b;
        POS_MAG_LO:  fr_mag[7:0] = b;
        default: ;
      endcase
      fr_xor ^= b;
      fr_pos = fr_pos + 1'b1;
    end else begin
      mag_ext = {1'b0, fr_mag};
      r.weight = '0;
      if (fr_product == cfg_product && fr_type == cfg_weight_type) begin
        if (fr_xor == b) begin
          r.kind = KIND_WEIGHT;
          r.weight = (fr_sign == NEG_SIGN_MARK) ? WEIGHT_W'(0) - mag_ext : mag_ext;
        end else begin
          r.kind = KIND_CSUM_ERR;
        end
      end else if (fr_product == cfg_product && fr_type == cfg_system_type) begin
        r.kind = KIND_TARE;
      end else begin
        r.kind = KIND_UNKNOWN;
      end
      decoded_q.push_back(r);
      fr_pos = '0;
      fr_xor = '0;
      fr_product = '0;
      fr_type = '0;
      fr_sign = '0;
      fr_mag = '0;
    end
  endtask

  // Driver: hold a stalled beat, otherwise send the next byte or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (rx_stream.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Track accepted bytes
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) decode_rx_byte(in_rx_byte);
  end

  // Monitor: check each result beat against the oldest decoded frame, then pick a stall
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result beat, kind %0d weight %0d",
                 $time, out_frame_kind, out_weight_hundredths);
        errors++;
      end else begin
        exp_r = decoded_q.pop_front();
        if (out_frame_kind !== exp_r.kind) begin
          $display("%0t: frame_kind expected %0d got %0d", $time, exp_r.kind, out_frame_kind);
          errors++;
        end
        if (out_weight_hundredths !== exp_r.weight) begin
          $display("%0t: weight_hundredths expected %0d got %0d",
                   $time, exp_r.weight, out_weight_hundredths);
          errors++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Write one register while the block is idle, and mirror it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PRODUCT_CODE: cfg_product = val;
      CFG_WEIGHT_TYPE:  cfg_weight_type = val;
      CFG_SYSTEM_TYPE:  cfg_system_type = val;
      default: ;
    endcase
  endtask

  // Hold off until every byte is sent and every result is back, then drain the pipe
  task automatic settle();
    while (rx_stream.size() > 0 || in_valid || decoded_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Append one frame with random filler; corrupt the checksum byte on request
  task automatic queue_frame(input logic [7:0] prod, input logic [7:0] typ,
                             input logic [7:0] sgn, input logic [MAG_W-1:0] mag,
                             input bit good_csum);
    logic [7:0] fb;
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
      case (POS_W'(i))
        POS_PRODUCT: fb = prod;
        POS_TYPE:    fb = typ;
        POS_SIGN:    fb = sgn;
        POS_MAG_HI:  fb = mag[23:16];
        POS_MAG_MID: fb = mag[15:8];
        POS_MAG_LO:  fb = mag[7:0];
        default:     fb = 8'($urandom());
      endcase
      acc ^= fb;
      rx_stream.push_back(fb);
    end
    rx_stream.push_back(good_csum ? acc : acc ^ 8'($urandom_range(1, 255)));
  endtask

  // Mostly well-formed weight frames, plus tare, foreign, corrupt and noise frames
  task automatic queue_random_frame();
    int pick;
    int sel;
    logic [7:0] sgn;
    logic [7:0] typ;
    logic [MAG_W-1:0] mag;
    pick = $urandom_range(99);
    sel = $urandom_range(7);
    mag = (sel == 0) ? '0 : (sel == 1) ? '1 : MAG_W'($urandom());
    sgn = $urandom_range(1) ? NEG_SIGN_MARK : 8'($urandom());
    typ = $urandom_range(1) ? cfg_weight_type : cfg_system_type;
    if (pick < 60) begin
      queue_frame(cfg_product, cfg_weight_type, sgn, mag, 1'b1);
    end else if (pick < 70) begin
      queue_frame(cfg_product, cfg_weight_type, sgn, mag, 1'b0);
    end else if (pick < 82) begin
      queue_frame(cfg_product, cfg_system_type, sgn, mag, $urandom_range(1));
    end else if (pick < 90) begin
      queue_frame(cfg_product ^ 8'($urandom_range(1, 255)), typ, sgn, mag, 1'b1);
    end else begin
      for (int i = 0; i < FRAME_LENGTH; i++) rx_stream.push_back(8'($urandom()));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Writes past the last register must change nothing
    write_reg(CFG_UNUSED, 8'($urandom()));

    // Directed frames under the reset codes
    queue_frame(cfg_product, cfg_weight_type, 8'd43, '1, 1'b1);
    queue_frame(cfg_product, cfg_weight_type, NEG_SIGN_MARK, '1, 1'b1);
    queue_frame(cfg_product, cfg_weight_type, NEG_SIGN_MARK, '0, 1'b1);
    queue_frame(cfg_product, cfg_weight_type, 8'hFF, '0, 1'b1);
    queue_frame(cfg_product, cfg_weight_type, NEG_SIGN_MARK, 24'h800001, 1'b0);
    queue_frame(cfg_product, cfg_system_type, 8'h00, 24'h123456, 1'b0);
    queue_frame(~cfg_product, cfg_weight_type, 8'h00, 24'h000100, 1'b1);
    queue_frame(cfg_product, 8'hFF, 8'h00, 24'h000100, 1'b1);

    // Random phases: new codes each time, and one of four idle/stall mixes in turn
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(CFG_PRODUCT_CODE, 8'h00);
          write_reg(CFG_WEIGHT_TYPE, 8'h00);
          write_reg(CFG_SYSTEM_TYPE, 8'h00);
        end
        1: begin
          write_reg(CFG_PRODUCT_CODE, 8'hFF);
          write_reg(CFG_WEIGHT_TYPE, 8'h00);
          write_reg(CFG_SYSTEM_TYPE, 8'hFF);
        end
        2: begin
          write_reg(CFG_PRODUCT_CODE, 8'hFF);
          write_reg(CFG_WEIGHT_TYPE, 8'hFF);
          write_reg(CFG_SYSTEM_TYPE, 8'hFF);
        end
        default: begin
          write_reg(CFG_PRODUCT_CODE, 8'($urandom()));
          write_reg(CFG_WEIGHT_TYPE, 8'($urandom()));
          write_reg(CFG_SYSTEM_TYPE,
                    $urandom_range(3) == 0 ? cfg_weight_type : 8'($urandom()));
        end
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      for (int f = 0; f < FRAMES_PER_PHASE; f++) queue_random_frame();
    end

    settle();
    if (errors == 0) begin
      $display("scale_weight_frame_decoder: match");
    end else begin
      $display("scale_weight_frame_decoder: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("scale_weight_frame_decoder: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/swfd_pkg.sv
sv/swfd_frame_capture.sv
sv/swfd_classify.sv
sv/scale_weight_frame_decoder.sv
sv/swfd_checker.sv
tb/testbench.sv
